// ===== rtl/radix_digit_converter_core_assert.svh =====
// assertion macros shared by the radix digit converter checkers
`ifndef RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RDC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rdc_pkg.sv =====
// types and constants for the radix digit converter
package rdc_pkg;

	localparam int VALUE_PORT_W = 64;
	localparam int VALUE_WIDTH_DEF = 64;
	localparam int MAX_DIGITS_DEF = 64;
	localparam int MAX_BASE_DEF = 16;
	localparam int MIN_BASE = 2;

	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 8;
	localparam int NUM_CHARS = 16;
	localparam int CHARS_W = 64;
	localparam int DIV_CHUNK = 8;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_READ,
		ST_OUT
	} rdc_state_t;

	typedef struct packed {
		logic load;
		logic start;
	} rdc_div_ctrl_t;

	typedef struct packed {
		logic done;
		logic quot_zero;
		logic [DIGIT_W-1:0] digit;
	} rdc_div_stat_t;

endpackage

// ===== rtl/rdc_ram.sv =====
// generic single-port-write ram with registered read
module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/rdc_divider.sv =====
// iterative divider by a small radix, one byte of dividend per cycle
module rdc_divider #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdc_pkg::rdc_div_ctrl_t      ctrl,
	input  logic [VALUE_WIDTH-1:0]      value_in,
	input  logic [rdc_pkg::RADIX_W-1:0] radix,
	output rdc_pkg::rdc_div_stat_t      stat
);

	localparam int CHUNK = rdc_pkg::DIV_CHUNK;
	localparam int STEPS = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
	localparam int PAD_W = STEPS * CHUNK;
	localparam int SC_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int DW = rdc_pkg::DIGIT_W;
	localparam int RW = rdc_pkg::RADIX_W;

	logic [PAD_W-1:0] quot_q;
	logic [PAD_W-1:0] quot_next;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    rem_next;
	logic [SC_W-1:0]  step_q;
	logic             busy_q;
	logic             last_step;
	logic [CHUNK-1:0] chunk;
	logic [CHUNK-1:0] qbits;
	logic [RW-1:0]    trial;
	logic [DW-1:0]    part_rem;

	// restoring division of the top byte, remainder stays below the radix
	always_comb begin
		chunk = quot_q[PAD_W-1 -: CHUNK];
		part_rem = rem_q;
		qbits = '0;
		trial = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			trial = {part_rem, chunk[i]};
			if (trial >= radix) begin
				qbits[i] = 1'b1;
				part_rem = DW'(trial - radix);
			end else begin
				qbits[i] = 1'b0;
				part_rem = trial[DW-1:0];
			end
		end
		rem_next = part_rem;
		quot_next = (quot_q << CHUNK) | PAD_W'(qbits);
	end

	assign last_step = (step_q == SC_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SC_W'(1);
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quot_q <= PAD_W'(value_in);
		end else if (busy_q) begin
			quot_q <= quot_next;
		end
		if (ctrl.start) begin
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
		end
	end

	assign stat.done = busy_q && last_step;
	assign stat.quot_zero = (quot_q == '0);
	assign stat.digit = rem_next;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// top level: unsigned value to base-n character stream
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid / in_ready   | value
//  out     | out_valid / out_ready | digit_char, last_digit
//
// each digit is produced by the shared divider, which takes one byte of the quotient
// per cycle while busy; each emitted digit then passes a digit ram read state and
// an output transfer state, and the transfer waits through output stalls.
// in_ready is high only when idle; cfg_ready is always high.
// reset clears the configuration to base 10 and all-zero characters.
module radix_digit_converter_core #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
	parameter int MAX_BASE = rdc_pkg::MAX_BASE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rdc_pkg::VALUE_PORT_W-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rdc_pkg::CHAR_W-1:0]     digit_char,
	output logic                           last_digit
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int RW = rdc_pkg::RADIX_W;
	localparam int DW = rdc_pkg::DIGIT_W;
	localparam int CW = rdc_pkg::CHAR_W;
	localparam int CHW = rdc_pkg::CHARS_W;

	rdc_pkg::rdc_state_t    state_q, state_d;
	rdc_pkg::rdc_div_ctrl_t div_ctrl;
	rdc_pkg::rdc_div_stat_t div_stat;

	logic [RW-1:0]    base_q;
	logic [CHW-1:0]   chars_lo_q;
	logic [CHW-1:0]   chars_hi_q;
	logic [RW-1:0]    radix;
	logic [CNT_W-1:0] count_q, count_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [DW-1:0]    ram_wdata;
	logic             ram_re;
	logic [DW-1:0]    ram_rdata;
	logic [2*CHW-1:0] chars_all;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= RW'(10);
			chars_lo_q <= '0;
			chars_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rdc_pkg::CFG_BASE_LENGTH: base_q <= cfg_data[RW-1:0];
				rdc_pkg::CFG_CHARS_LOW:   chars_lo_q <= cfg_data;
				rdc_pkg::CFG_CHARS_HIGH:  chars_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (base_q < RW'(rdc_pkg::MIN_BASE)) begin
			radix = RW'(rdc_pkg::MIN_BASE);
		end else if (base_q > RW'(MAX_BASE)) begin
			radix = RW'(MAX_BASE);
		end else begin
			radix = base_q;
		end
	end

	rdc_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(div_ctrl),
		.value_in(value[VALUE_WIDTH-1:0]),
		.radix(radix),
		.stat(div_stat)
	);

	rdc_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_DIGITS)
	) u_digit_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en(ram_re),
		.rd_addr(idx_q),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdc_pkg::ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d = idx_q;
		div_ctrl = '0;
		ram_we = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = div_stat.digit;
		ram_re = 1'b0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			rdc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					div_ctrl.load = 1'b1;
					count_d = '0;
					state_d = rdc_pkg::ST_CHECK;
				end
			end
			rdc_pkg::ST_CHECK: begin
				if (div_stat.quot_zero && (count_q == '0)) begin
					// zero value gives the single digit zero
					ram_we = 1'b1;
					ram_waddr = '0;
					ram_wdata = '0;
					count_d = CNT_W'(1);
					idx_d = '0;
					state_d = rdc_pkg::ST_READ;
				end else if (!div_stat.quot_zero && (count_q < CNT_W'(MAX_DIGITS))) begin
					div_ctrl.start = 1'b1;
					state_d = rdc_pkg::ST_DIV;
				end else begin
					idx_d = AW'(count_q - CNT_W'(1));
					state_d = rdc_pkg::ST_READ;
				end
			end
			rdc_pkg::ST_DIV: begin
				if (div_stat.done) begin
					ram_we = 1'b1;
					count_d = count_q + CNT_W'(1);
					state_d = rdc_pkg::ST_CHECK;
				end
			end
			rdc_pkg::ST_READ: begin
				ram_re = 1'b1;
				state_d = rdc_pkg::ST_OUT;
			end
			rdc_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (idx_q == '0) begin
						state_d = rdc_pkg::ST_IDLE;
					end else begin
						idx_d = idx_q - AW'(1);
						state_d = rdc_pkg::ST_READ;
					end
				end
			end
			default: state_d = rdc_pkg::ST_IDLE;
		endcase
	end

	assign chars_all = {chars_hi_q, chars_lo_q};
	assign digit_char = chars_all[{ram_rdata, 3'b000} +: CW];
	assign last_digit = (idx_q == '0);

endmodule

// ===== rtl/rdc_checker.sv =====
// port-level checks for the radix digit converter, bound to the top level
`include "radix_digit_converter_core_assert.svh"

module rdc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [rdc_pkg::CHAR_W-1:0]       digit_char,
	input logic                             last_digit
);

	// output and input side never open together
	`RDC_ASSERT_IMP(a_out_blocks_in, out_valid, !in_ready, "in_ready high while output pending")

	// an accepted value keeps the input closed in the next cycle
	`RDC_ASSERT_NEXT(a_in_closes, in_valid && in_ready, !in_ready, "in_ready high after transfer")

	// a stalled digit holds its payload
	`RDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(digit_char) && $stable(last_digit), "stalled digit changed")

	// the final digit returns the block to idle
	`RDC_ASSERT_NEXT(a_last_idle, out_valid && out_ready && last_digit,
		in_ready && !out_valid, "not idle after final digit")

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.digit_char(digit_char),
	.last_digit(last_digit)
);
